// ===== rtl/nearest_point_on_polyline_unit_macros.svh =====
// assertion macros for the nearest point on polyline unit
`ifndef NEAREST_POINT_ON_POLYLINE_UNIT_MACROS_SVH
`define NEAREST_POINT_ON_POLYLINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define NPP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define NPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/npp_pkg.sv =====
// shared widths, types and codes of the nearest point on polyline unit
package npp_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MUL_W      = COORD_BITS + 2;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LEN_W      = 2 * COORD_BITS + 2;
    localparam int DOTM_W     = 2 * COORD_BITS + 2;
    localparam int NUM_W      = 3 * COORD_BITS + 2;
    localparam int QUOT_W     = COORD_BITS + 1;
    localparam int CNT_W      = $clog2(QUOT_W);
    localparam int FOOT_W     = COORD_BITS + 3;
    localparam int DIST_W     = 2 * COORD_BITS + 3;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         final_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] nearest_x;
        logic signed [COORD_BITS-1:0] nearest_y;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST_X,
        S_DIST_Y,
        S_DIST_CMP,
        S_LEN_X,
        S_LEN_Y,
        S_DOT_X,
        S_DOT_Y,
        S_DOT_SUM,
        S_NUM_LO,
        S_NUM_HI,
        S_DIV_START,
        S_DIV_WAIT,
        S_FOOT,
        S_BOX,
        S_DONE
    } t_state;

endpackage

// ===== rtl/npp_div.sv =====
// restoring divider, one quotient bit per cycle
module npp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [npp_pkg::NUM_W-1:0]  i_num,
    input  logic [npp_pkg::LEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [npp_pkg::QUOT_W-1:0] o_quot
);
    import npp_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [LEN_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_nlo;
    logic [QUOT_W-1:0] r_quot;

    logic [LEN_W:0]    trial;
    logic [LEN_W+1:0]  diff;
    logic              take;

    assign trial = {r_rem, r_nlo[QUOT_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, i_den};
    assign take  = ~diff[LEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= LEN_W'(i_num[NUM_W-1:QUOT_W]);
            r_nlo <= i_num[QUOT_W-1:0];
        end else if (r_busy) begin
            r_rem  <= take ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_nlo  <= {r_nlo[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/nearest_point_on_polyline_unit.sv =====
// nearest point on polyline: sequencer, shared multiplier and candidate tracking
//
// Vertices arrive one item at a time as signed Q12.12 points; the query point sits in
// two config registers (index 0 x, index 1 y). Every vertex and every in-box foot of
// the perpendicular onto a segment is a candidate; the first one with the smallest
// squared distance wins. An item flagged final_vertex produces one result (the best
// point) and clears the polyline state. The block takes one item at a time and drops
// ready while it works. All products run through one 26x26 multiplier, one per cycle,
// and the two foot offsets go through one restoring divider at one quotient bit per
// cycle. A first vertex only weighs its own distance, a zero-length segment stops
// once its length is known, and any other vertex also runs both divisions before
// ready returns. A final result waits in an output register; the next item is taken
// while it waits, but a later final result holds until it is taken.
module nearest_point_on_polyline_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [npp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [npp_pkg::COORD_BITS-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  npp_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output npp_pkg::t_out_item                o_out_data
);
    import npp_pkg::*;

    localparam int C = COORD_BITS;

    t_state                    r_state, n_state;
    logic signed [C-1:0]       r_qx, n_qx, r_qy, n_qy;
    logic signed [C-1:0]       r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic                      r_final, n_final;
    logic signed [C-1:0]       r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic                      r_have_prev, n_have_prev;
    logic signed [C-1:0]       r_best_x, n_best_x, r_best_y, n_best_y;
    logic [DIST_W-1:0]         r_best_dist, n_best_dist;
    logic signed [DIFF_W-1:0]  r_dx, n_dx, r_dy, n_dy;
    logic signed [DIFF_W-1:0]  r_vx, n_vx, r_vy, n_vy;
    logic signed [DIFF_W-1:0]  r_ux, n_ux, r_uy, n_uy;
    logic                      r_foot_phase, n_foot_phase;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [PROD_W-1:0]  r_acc, n_acc;
    logic [LEN_W-1:0]          r_len2, n_len2;
    logic [DOTM_W-1:0]         r_dot_mag, n_dot_mag;
    logic                      r_dot_neg, n_dot_neg;
    logic [C-1:0]              r_vmag, n_vmag;
    logic                      r_vneg, n_vneg;
    logic                      r_comp, n_comp;
    logic signed [FOOT_W-1:0]  r_foot_x, n_foot_x, r_foot_y, n_foot_y;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_data, n_out_data;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W:0]    acc_sum;
    logic [PROD_W:0]           dot_abs;
    logic [NUM_W-1:0]          num;
    logic                      div_start;
    logic                      div_done;
    logic [QUOT_W-1:0]         div_quot;
    logic signed [C-1:0]       cand_x, cand_y;
    logic signed [FOOT_W-1:0]  quot_w, offset, prev_c, foot_c;
    logic signed [FOOT_W-1:0]  px_w, py_w, cx_w, cy_w;
    logic signed [FOOT_W-1:0]  fdx, fdy;
    logic                      in_box;
    logic signed [C-1:0]       vin_x, vin_y;

    npp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (r_len2),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign vin_x   = i_in_data.vertex_x;
    assign vin_y   = i_in_data.vertex_y;
    assign acc_sum = {r_acc[PROD_W-1], r_acc} + {r_prod[PROD_W-1], r_prod};
    assign dot_abs = acc_sum[PROD_W] ? $unsigned(-acc_sum) : $unsigned(acc_sum);
    assign num     = NUM_W'($unsigned(r_acc)) + (NUM_W'($unsigned(r_prod)) << (C + 1));
    assign cand_x  = r_foot_phase ? r_foot_x[C-1:0] : r_cur_x;
    assign cand_y  = r_foot_phase ? r_foot_y[C-1:0] : r_cur_y;

    assign quot_w  = signed'(FOOT_W'(div_quot));
    assign offset  = (r_vneg ^ r_dot_neg) ? -quot_w : quot_w;
    assign prev_c  = r_comp ? FOOT_W'(r_prev_y) : FOOT_W'(r_prev_x);
    assign foot_c  = prev_c + offset;

    assign px_w    = FOOT_W'(r_prev_x);
    assign py_w    = FOOT_W'(r_prev_y);
    assign cx_w    = FOOT_W'(r_cur_x);
    assign cy_w    = FOOT_W'(r_cur_y);
    assign in_box  = ((r_foot_x >= px_w && r_foot_x <= cx_w) ||
                      (r_foot_x >= cx_w && r_foot_x <= px_w)) &&
                     ((r_foot_y >= py_w && r_foot_y <= cy_w) ||
                      (r_foot_y >= cy_w && r_foot_y <= py_w));
    assign fdx     = FOOT_W'(r_qx) - r_foot_x;
    assign fdy     = FOOT_W'(r_qy) - r_foot_y;

    assign n_prod  = mul_a * mul_b;

    always_comb begin
        n_state      = r_state;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_final      = r_final;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_have_prev  = r_have_prev;
        n_best_x     = r_best_x;
        n_best_y     = r_best_y;
        n_best_dist  = r_best_dist;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_vx         = r_vx;
        n_vy         = r_vy;
        n_ux         = r_ux;
        n_uy         = r_uy;
        n_foot_phase = r_foot_phase;
        n_acc        = r_acc;
        n_len2       = r_len2;
        n_dot_mag    = r_dot_mag;
        n_dot_neg    = r_dot_neg;
        n_vmag       = r_vmag;
        n_vneg       = r_vneg;
        n_comp       = r_comp;
        n_foot_x     = r_foot_x;
        n_foot_y     = r_foot_y;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        o_in_ready   = 1'b0;

        if (i_cfg_we && i_cfg_idx == REG_QUERY_X) begin
            n_qx = i_cfg_data;
        end
        if (i_cfg_we && i_cfg_idx == REG_QUERY_Y) begin
            n_qy = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cur_x      = vin_x;
                    n_cur_y      = vin_y;
                    n_final      = i_in_data.final_vertex;
                    n_dx         = DIFF_W'(r_qx) - DIFF_W'(vin_x);
                    n_dy         = DIFF_W'(r_qy) - DIFF_W'(vin_y);
                    n_vx         = DIFF_W'(vin_x) - DIFF_W'(r_prev_x);
                    n_vy         = DIFF_W'(vin_y) - DIFF_W'(r_prev_y);
                    n_ux         = DIFF_W'(r_qx) - DIFF_W'(r_prev_x);
                    n_uy         = DIFF_W'(r_qy) - DIFF_W'(r_prev_y);
                    n_foot_phase = 1'b0;
                    n_state      = S_DIST_X;
                end
            end
            S_DIST_X: begin
                mul_a   = MUL_W'(r_dx);
                mul_b   = MUL_W'(r_dx);
                n_state = S_DIST_Y;
            end
            S_DIST_Y: begin
                mul_a   = MUL_W'(r_dy);
                mul_b   = MUL_W'(r_dy);
                n_acc   = r_prod;
                n_state = S_DIST_CMP;
            end
            S_DIST_CMP: begin
                if (acc_sum[DIST_W-1:0] < r_best_dist) begin
                    n_best_dist = acc_sum[DIST_W-1:0];
                    n_best_x    = cand_x;
                    n_best_y    = cand_y;
                end
                if (!r_foot_phase && r_have_prev) begin
                    n_state = S_LEN_X;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LEN_X: begin
                mul_a   = MUL_W'(r_vx);
                mul_b   = MUL_W'(r_vx);
                n_state = S_LEN_Y;
            end
            S_LEN_Y: begin
                mul_a   = MUL_W'(r_vy);
                mul_b   = MUL_W'(r_vy);
                n_acc   = r_prod;
                n_state = S_DOT_X;
            end
            S_DOT_X: begin
                mul_a  = MUL_W'(r_vx);
                mul_b  = MUL_W'(r_ux);
                n_len2 = acc_sum[LEN_W-1:0];
                if (acc_sum[LEN_W-1:0] == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DOT_Y;
                end
            end
            S_DOT_Y: begin
                mul_a   = MUL_W'(r_vy);
                mul_b   = MUL_W'(r_uy);
                n_acc   = r_prod;
                n_state = S_DOT_SUM;
            end
            S_DOT_SUM: begin
                n_dot_mag = dot_abs[DOTM_W-1:0];
                n_dot_neg = acc_sum[PROD_W];
                n_comp    = 1'b0;
                n_vmag    = r_vx[DIFF_W-1] ? C'($unsigned(-r_vx)) : C'($unsigned(r_vx));
                n_vneg    = r_vx[DIFF_W-1];
                n_state   = S_NUM_LO;
            end
            S_NUM_LO: begin
                mul_a   = signed'(MUL_W'(r_vmag));
                mul_b   = signed'(MUL_W'(r_dot_mag[C:0]));
                n_state = S_NUM_HI;
            end
            S_NUM_HI: begin
                mul_a   = signed'(MUL_W'(r_vmag));
                mul_b   = signed'(MUL_W'(r_dot_mag[DOTM_W-1:C+1]));
                n_acc   = r_prod;
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_FOOT;
                end
            end
            S_FOOT: begin
                if (!r_comp) begin
                    n_foot_x = foot_c;
                    n_comp   = 1'b1;
                    n_vmag   = r_vy[DIFF_W-1] ? C'($unsigned(-r_vy)) : C'($unsigned(r_vy));
                    n_vneg   = r_vy[DIFF_W-1];
                    n_state  = S_NUM_LO;
                end else begin
                    n_foot_y = foot_c;
                    n_state  = S_BOX;
                end
            end
            S_BOX: begin
                if (in_box) begin
                    n_foot_phase = 1'b1;
                    n_dx         = fdx[DIFF_W-1:0];
                    n_dy         = fdy[DIFF_W-1:0];
                    n_state      = S_DIST_X;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_final) begin
                    n_prev_x    = r_cur_x;
                    n_prev_y    = r_cur_y;
                    n_have_prev = 1'b1;
                    n_state     = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out_data.nearest_x = r_best_x;
                    n_out_data.nearest_y = r_best_y;
                    n_prev_x             = '0;
                    n_prev_y             = '0;
                    n_have_prev          = 1'b0;
                    n_best_x             = '0;
                    n_best_y             = '0;
                    n_best_dist          = '1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qx        <= '0;
            r_qy        <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_dist <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qx        <= n_qx;
            r_qy        <= n_qy;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_have_prev <= n_have_prev;
            r_best_x    <= n_best_x;
            r_best_y    <= n_best_y;
            r_best_dist <= n_best_dist;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x      <= n_cur_x;
        r_cur_y      <= n_cur_y;
        r_final      <= n_final;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_vx         <= n_vx;
        r_vy         <= n_vy;
        r_ux         <= n_ux;
        r_uy         <= n_uy;
        r_foot_phase <= n_foot_phase;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_len2       <= n_len2;
        r_dot_mag    <= n_dot_mag;
        r_dot_neg    <= n_dot_neg;
        r_vmag       <= n_vmag;
        r_vneg       <= n_vneg;
        r_comp       <= n_comp;
        r_foot_x     <= n_foot_x;
        r_foot_y     <= n_foot_y;
        r_out_data   <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/npp_checker.sv =====
// port-level assertions for the nearest point on polyline unit, with its bind
`include "nearest_point_on_polyline_unit_macros.svh"

module npp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input npp_pkg::t_out_item             o_out_data
);
    import npp_pkg::*;

    // a result waiting for the sink stays put
    `NPP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    // one item at a time: ready falls once an item is taken
    `NPP_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "item taken while the previous one is still in work")

    // a result only appears at the end of an item's work
    `NPP_ASSERT_SAME(a_result_from_work, $rose(o_out_valid), $past(!o_in_ready),
        "result appeared without an item in work")

    // taking an item while no result waits does not raise a result right after it
    `NPP_ASSERT_NEXT(a_no_early_result, i_in_valid && o_in_ready && !o_out_valid,
        !o_out_valid, "result appeared right after an item was taken")

endmodule

bind nearest_point_on_polyline_unit npp_checker u_npp_checker (.*);

// ===== sim/nearest_point_on_polyline_unit_test.sv =====
// testbench for the nearest point on polyline unit: directed and random polylines checked against a predictor
`timescale 1ns / 1ps

module nearest_point_on_polyline_unit_test;
    import npp_pkg::*;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef enum int {SHAPE_LOCAL, SHAPE_WIDE, SHAPE_EDGE} t_shape;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    localparam longint COORD_MAX  = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN  = -(longint'(1) << (COORD_BITS - 1));
    localparam int     LONG_HOLD  = 3000;
    localparam int     IDLE_GAP   = 150;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [COORD_BITS-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    nearest_point_on_polyline_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    longint    query_x = 0, query_y = 0;
    longint    prev_x = 0, prev_y = 0;
    bit        have_prev = 1'b0;
    longint    best_x = 0, best_y = 0;
    longint    best_sq = COORD_MAX * COORD_MAX * 16;

    t_in_item  vertex_backlog[$];
    t_out_item nearest_due[$];
    int        vertices_sent = 0;
    int        vertices_taken = 0;
    int        mismatch_cnt = 0;
    bit        long_hold_req = 1'b0;

    task automatic weigh_candidate(input longint x, input longint y);
        longint dx, dy, d;
        dx = query_x - x;
        dy = query_y - y;
        d  = dx * dx + dy * dy;
        if (d < best_sq) begin
            best_sq = d;
            best_x  = x;
            best_y  = y;
        end
    endtask

    task automatic track_vertex(input t_in_item it);
        longint cx, cy, vx, vy, ux, uy, len2, dot, fx, fy;
        logic signed [127:0] w_dot, w_len, w_vx, w_vy;
        t_out_item res;
        cx = $signed(it.vertex_x);
        cy = $signed(it.vertex_y);
        weigh_candidate(cx, cy);
        if (have_prev) begin
            vx   = cx - prev_x;
            vy   = cy - prev_y;
            ux   = query_x - prev_x;
            uy   = query_y - prev_y;
            len2 = vx * vx + vy * vy;
            if (len2 != 0) begin
                dot   = vx * ux + vy * uy;
                w_dot = dot;
                w_len = len2;
                w_vx  = vx;
                w_vy  = vy;
                fx = prev_x + longint'((w_vx * w_dot) / w_len);
                fy = prev_y + longint'((w_vy * w_dot) / w_len);
                if (fx >= (prev_x < cx ? prev_x : cx) && fx <= (prev_x < cx ? cx : prev_x) &&
                    fy >= (prev_y < cy ? prev_y : cy) && fy <= (prev_y < cy ? cy : prev_y)) begin
                    weigh_candidate(fx, fy);
                end
            end
        end
        prev_x    = cx;
        prev_y    = cy;
        have_prev = 1'b1;
        if (it.final_vertex) begin
            res.nearest_x = best_x[COORD_BITS-1:0];
            res.nearest_y = best_y[COORD_BITS-1:0];
            nearest_due = {nearest_due, res};
            prev_x    = 0;
            prev_y    = 0;
            have_prev = 1'b0;
            best_x    = 0;
            best_y    = 0;
            best_sq   = COORD_MAX * COORD_MAX * 16;
        end
    endtask

    // sender: bursts of random length with random gaps
    bit       drv_valid;
    t_in_item drv_data;
    int       burst_left = 1;
    int       gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            drv_valid = i_in_valid;
            drv_data  = i_in_data;
            if (i_in_valid && o_in_ready) begin
                track_vertex(i_in_data);
                vertices_taken++;
                drv_valid = 1'b0;
            end
            if (!drv_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (vertex_backlog.size() > 0) begin
                    drv_data  = vertex_backlog.pop_front();
                    drv_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(1, 4);
                            2: gap_left = $urandom_range(5, 90);
                            default: gap_left = $urandom_range(0, 2);
                        endcase
                    end
                end
            end
            i_in_valid <= drv_valid;
            i_in_data  <= drv_data;
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off
    t_rx_mode  rx_mode = RX_OPEN;
    int        mode_left = 0;
    int        hold_left = 0;
    bit        long_hold_done = 1'b0;
    logic [7:0] stall_pat = 8'hff;
    bit        rdy;
    t_out_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (nearest_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: got (%0d, %0d)",
                                 o_out_data.nearest_x, o_out_data.nearest_y);
                end else begin
                    want = nearest_due.pop_front();
                    if (o_out_data.nearest_x !== want.nearest_x ||
                        o_out_data.nearest_y !== want.nearest_y) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("nearest point mismatch: expected (%0d, %0d) got (%0d, %0d)",
                                     want.nearest_x, want.nearest_y,
                                     o_out_data.nearest_x, o_out_data.nearest_y);
                    end
                end
            end
            if (long_hold_req && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                    stall_pat = 8'($urandom_range(1, 255));
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_COIN:   rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 7) == 0);
                    default: begin
                        rdy       = stall_pat[0];
                        stall_pat = {stall_pat[0], stall_pat[7:1]};
                    end
                endcase
            end
            i_out_ready <= rdy;
        end
    end

    // stimulus helpers
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic longint rand_coord();
        t_coord c;
        c = t_coord'($urandom);
        return longint'(c);
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic longint edge_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return rand_coord();
        endcase
    endfunction

    task automatic add_vertex(input longint x, input longint y, input bit last);
        t_in_item it;
        it.vertex_x     = x[COORD_BITS-1:0];
        it.vertex_y     = y[COORD_BITS-1:0];
        it.final_vertex = last;
        vertex_backlog = {vertex_backlog, it};
        vertices_sent++;
    endtask

    task automatic add_polyline(input int n, input bit close);
        t_shape shape;
        longint px, py, dx, dy, span, nx, ny;
        int k, pick;
        pick  = $urandom_range(0, 9);
        shape = pick < 6 ? SHAPE_LOCAL : (pick < 8 ? SHAPE_WIDE : SHAPE_EDGE);
        span  = longint'(1) << $urandom_range(2, 21);
        px = 0; py = 0; dx = 0; dy = 0;
        for (k = 0; k < n; k++) begin
            case (shape)
                SHAPE_LOCAL: begin
                    pick = $urandom_range(0, 19);
                    if (k == 0) begin
                        nx = clamp_coord(query_x + jitter(span));
                        ny = clamp_coord(query_y + jitter(span));
                    end else if (pick < 2) begin
                        nx = px;
                        ny = py;
                    end else if (pick < 5) begin
                        nx = clamp_coord(px + dx);
                        ny = clamp_coord(py + dy);
                    end else begin
                        nx = clamp_coord(px + jitter(span));
                        ny = clamp_coord(py + jitter(span));
                    end
                end
                SHAPE_WIDE: begin
                    nx = rand_coord();
                    ny = rand_coord();
                end
                default: begin
                    nx = edge_coord();
                    ny = edge_coord();
                end
            endcase
            add_vertex(nx, ny, close && (k == n - 1));
            dx = nx - px;
            dy = ny - py;
            px = nx;
            py = ny;
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (vertices_taken != vertices_sent || nearest_due.size() != 0);
    endtask

    task automatic set_query(input longint qx, input longint qy);
        wait_idle();
        repeat (IDLE_GAP) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_QUERY_X;
        i_cfg_data <= qx[COORD_BITS-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= REG_QUERY_Y;
        i_cfg_data <= qy[COORD_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        query_x = qx;
        query_y = qy;
    endtask

    int ph, n, target;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        set_query(0, 0);
        add_vertex(3, 4, 1'b0);
        add_vertex(4, 3, 1'b1);
        add_vertex(10, 0, 1'b0);
        add_vertex(0, 10, 1'b1);
        add_vertex(100, 0, 1'b0);
        add_vertex(200, 0, 1'b1);
        add_vertex(COORD_MIN, COORD_MIN, 1'b0);
        add_vertex(COORD_MAX, COORD_MAX, 1'b1);
        add_vertex(-8192, 0, 1'b0);
        add_vertex(-4096, 0, 1'b0);
        add_vertex(4096, 0, 1'b1);
        add_vertex(0, 0, 1'b1);
        set_query(COORD_MAX, COORD_MIN);
        add_vertex(COORD_MAX, COORD_MIN, 1'b1);
        add_vertex(-4096, -4096, 1'b0);
        add_vertex(-4096, -4096, 1'b0);
        add_vertex(8192, -4096, 1'b0);
        add_vertex(20480, -4096, 1'b1);
        add_vertex(5000, -7000, 1'b0);
        add_vertex(-3000, 9000, 1'b0);
        // query moves in the middle of a polyline
        set_query(COORD_MIN, COORD_MAX);
        add_vertex(COORD_MIN, COORD_MIN, 1'b0);
        add_vertex(COORD_MAX, COORD_MIN, 1'b1);
        add_vertex(COORD_MIN, COORD_MAX, 1'b1);

        // random part
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_query(rand_coord(), rand_coord());
                1: set_query(COORD_MAX, COORD_MAX);
                2: set_query(jitter(4096), jitter(4096));
                3: set_query(COORD_MIN, COORD_MIN);
                default: set_query(rand_coord(), rand_coord());
            endcase
            if (ph == 1)
                long_hold_req = 1'b1;
            target = vertices_sent + 221;
            while (vertices_sent < target) begin
                case ($urandom_range(0, 19))
                    0: n = 1;
                    1, 2, 3, 4: n = $urandom_range(7, 15);
                    default: n = $urandom_range(1, 6);
                endcase
                add_polyline(n, 1'b1);
            end
            // sometimes leave a polyline open across the query change
            if ($urandom_range(0, 1))
                add_polyline($urandom_range(1, 4), 1'b0);
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
